// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PLAIN = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_HEX2  = 3'd4,
    MODE_HEX3  = 3'd5,
    MODE_HEX4  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_TRUNC_UNI    = 3'd2,
    ERR_BAD_DIGIT    = 3'd3,
    ERR_BAD_ESCAPE   = 3'd4
  } err_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

  localparam int MAX_RESULTS = 3;

  // Results of one input beat: all share one kind and error code.
  typedef struct packed {
    logic [1:0]                  cnt;
    kind_t                       kind;
    err_t                        err;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } bundle_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/json_string_unescape_core.sv =====
`timescale 1ns / 1ps

// Decodes a JSON string body one byte per beat, starting after the opening
// quote. Every input beat is decoded in the cycle it is accepted, and its
// results show on the output from the next cycle at the earliest. An input
// beat can be taken every clock while the output drains. A \uXXXX escape above
// U+007F yields two or three UTF-8 bytes, leaving one per cycle while out_ready
// is high. A second decoded beat is held behind them. The input stalls while
// both the emitting and the held beat are occupied and the emitting run is not
// leaving. This includes beats that give no result (start, backslash, the u
// of a \u escape, the first three hex digits, idle bytes). Every result beat
// carries last_of_run on the final result of its input beat.

module json_string_unescape_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] error_code,
  output logic       last_of_run
);
  import jsu_pkg::*;

  bundle_t bundle;
  logic    accept, push, can_take;

  assign in_ready = can_take;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (bundle.cnt != 2'd0);

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .data_byte (data_byte),
    .bundle    (bundle)
  );

  jsu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .bundle      (bundle),
    .can_take    (can_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  // Completion and errors are always single-result runs
  a_single_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_BYTE |-> last_of_run)
    else $error("status result not marked last of run");

  // Error code present exactly on error results
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // Bytes of one multi-byte run follow with no gap
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && out_kind == KIND_BYTE)
    else $error("multi-byte run broken");

  // Non-byte results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_BYTE |-> out_byte == 8'd0)
    else $error("status result carries a byte");

endmodule

// ===== hw/rtl/jsu_decode.sv =====
`timescale 1ns / 1ps

module jsu_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        data_byte,
  output jsu_pkg::bundle_t  bundle
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [4:0]  hex;
  logic [15:0] code;
  action_t     act;

  assign act  = action_t'(action);
  assign hex  = hex_digit(data_byte);
  assign code = {acc, hex[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  // Next state
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    if (act == ACT_START) begin
      mode_next = MODE_PLAIN;
      acc_next  = '0;
    end else if (act == ACT_NONE || mode == MODE_IDLE) begin
      mode_next = mode;
    end else if (act == ACT_END) begin
      mode_next = MODE_IDLE;
      acc_next  = '0;
    end else begin
      unique case (mode)
        MODE_PLAIN: begin
          if (data_byte == CH_QUOTE) mode_next = MODE_IDLE;
          else if (data_byte == CH_BSLASH) mode_next = MODE_ESC;
        end
        MODE_ESC: begin
          case (data_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N, CH_R, CH_T: mode_next = MODE_PLAIN;
            CH_U: begin
              mode_next = MODE_HEX1;
              acc_next  = '0;
            end
            default: mode_next = MODE_IDLE;
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          if (!hex[4]) begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
          end else begin
            mode_next = mode_t'(mode + 3'd1);
            acc_next  = {acc[7:0], hex[3:0]};
          end
        end
        MODE_HEX4: begin
          acc_next  = '0;
          mode_next = hex[4] ? MODE_PLAIN : MODE_IDLE;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  // Results
  always_comb begin
    bundle      = '0;
    bundle.kind = KIND_BYTE;
    bundle.err  = ERR_NONE;
    if (act == ACT_START || act == ACT_NONE || mode == MODE_IDLE) begin
      bundle.cnt = 2'd0;
    end else if (act == ACT_END) begin
      bundle.cnt  = 2'd1;
      bundle.kind = KIND_ERROR;
      bundle.err  = (mode == MODE_PLAIN || mode == MODE_ESC) ? ERR_UNTERMINATED
                                                             : ERR_TRUNC_UNI;
    end else begin
      unique case (mode)
        MODE_PLAIN: begin
          if (data_byte == CH_QUOTE) begin
            bundle.cnt  = 2'd1;
            bundle.kind = KIND_DONE;
          end else if (data_byte != CH_BSLASH) begin
            bundle.cnt      = 2'd1;
            bundle.bytes[0] = data_byte;
          end
        end
        MODE_ESC: begin
          bundle.cnt = 2'd1;
          case (data_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: bundle.bytes[0] = data_byte;
            CH_N: bundle.bytes[0] = 8'h0A;
            CH_R: bundle.bytes[0] = 8'h0D;
            CH_T: bundle.bytes[0] = 8'h09;
            CH_U: bundle.cnt = 2'd0;
            default: begin
              bundle.kind = KIND_ERROR;
              bundle.err  = ERR_BAD_ESCAPE;
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!hex[4]) begin
            bundle.cnt  = 2'd1;
            bundle.kind = KIND_ERROR;
            bundle.err  = ERR_BAD_DIGIT;
          end else if (mode == MODE_HEX4) begin
            if (code[15:7] == '0) begin
              bundle.cnt      = 2'd1;
              bundle.bytes[0] = code[7:0];
            end else if (code[15:11] == '0) begin
              bundle.cnt      = 2'd2;
              bundle.bytes[0] = UTF8_LEAD2 | {3'd0, code[10:6]};
              bundle.bytes[1] = UTF8_CONT | {2'd0, code[5:0]};
            end else begin
              bundle.cnt      = 2'd3;
              bundle.bytes[0] = UTF8_LEAD3 | {4'd0, code[15:12]};
              bundle.bytes[1] = UTF8_CONT | {2'd0, code[11:6]};
              bundle.bytes[2] = UTF8_CONT | {2'd0, code[5:0]};
            end
          end
        end
        default: bundle.cnt = 2'd0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/jsu_emit.sv =====
`timescale 1ns / 1ps

module jsu_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::bundle_t bundle,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [2:0]       error_code,
  output logic             last_of_run
);
  import jsu_pkg::*;

  bundle_t    pend, cur;
  logic       pend_valid, cur_valid;
  logic [1:0] idx;
  logic       at_last, load;

  assign at_last  = (idx == cur.cnt - 2'd1);
  assign load     = !cur_valid || (out_ready && at_last);
  assign can_take = !pend_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        idx <= '0;
        if (pend_valid) begin
          cur_valid <= 1'b1;
          pend_valid <= push;
        end else begin
          cur_valid <= push;
        end
      end else begin
        if (out_ready) idx <= idx + 2'd1;
        if (push) pend_valid <= 1'b1;
      end
    end
  end

  // Payload: a pending bundle moves up first, a fresh one fills the free slot
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        cur <= pend;
        if (push) pend <= bundle;
      end else if (push) begin
        cur <= bundle;
      end
    end else if (push) begin
      pend <= bundle;
    end
  end

  assign out_valid   = cur_valid;
  assign out_kind    = cur.kind;
  assign error_code  = cur.err;
  assign out_byte    = cur.bytes[idx];
  assign last_of_run = at_last;

endmodule
